// ===== design/rlsd_pkg.sv =====
// rlsd_pkg: shared types and constants for the RGB LED serial driver.
// No dependencies; imported by the pixel store, engine and top level.
package rlsd_pkg;

  localparam int NUM_PIXELS     = 4;
  localparam int BITS_PER_PIXEL = 24;
  localparam int PIX_W          = (NUM_PIXELS > 1) ? $clog2(NUM_PIXELS) : 1;
  localparam int CNT_W          = $clog2(NUM_PIXELS + 1);
  localparam int BIT_W          = $clog2(BITS_PER_PIXEL);
  localparam int CFG_DATA_W     = 16;
  localparam int CFG_IDX_W      = 3;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_START = 2'd1,
    OP_TICK  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_SEND  = 2'd1,
    PH_LATCH = 2'd2
  } phase_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ONE_HIGH  = 3'd0,
    CFG_ZERO_HIGH = 3'd1,
    CFG_PERIOD    = 3'd2,
    CFG_LATCH_GAP = 3'd3,
    CFG_LEDS      = 3'd4
  } cfg_idx_t;

  localparam logic [7:0]  RST_ONE_HIGH  = 8'd15;
  localparam logic [7:0]  RST_ZERO_HIGH = 8'd8;
  localparam logic [9:0]  RST_PERIOD    = 10'd24;
  localparam logic [15:0] RST_LATCH_GAP = 16'd960;
  localparam logic [2:0]  RST_LEDS      = 3'd4;

  typedef struct packed {
    logic [7:0]  one_high;
    logic [7:0]  zero_high;
    logic [9:0]  period;
    logic [15:0] latch_gap;
    logic [2:0]  leds;
  } cfg_t;

  typedef struct packed {
    logic [1:0] operation;
    logic [1:0] pixel_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } item_t;

  typedef struct packed {
    logic line_level;
    logic busy_res;
    logic frame_done;
  } res_t;

  typedef struct packed {
    logic                      en;
    logic [PIX_W-1:0]          idx;
    logic [BITS_PER_PIXEL-1:0] data;
  } store_wr_t;

endpackage

// ===== design/rlsd_if.sv =====
// Word channels of the RGB LED serial driver: command input and result output.
// Depends on nothing; widths follow the field list.
interface rlsd_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [1:0] pixel_index;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, operation, pixel_index, red, green, blue, input ready);
  modport sink   (input valid, operation, pixel_index, red, green, blue, output ready);
  modport monitor (input valid, ready, operation, pixel_index, red, green, blue);
endinterface

interface rlsd_out_if;
  logic valid;
  logic ready;
  logic line_level;
  logic busy_res;
  logic frame_done;

  modport source (output valid, line_level, busy_res, frame_done, input ready);
  modport sink   (input valid, line_level, busy_res, frame_done, output ready);
  modport monitor (input valid, ready, line_level, busy_res, frame_done);
endinterface

// ===== design/rlsd_pixel_store.sv =====
// rlsd_pixel_store: four-entry GRB pixel store, cleared at reset.
// Depends on rlsd_pkg.
module rlsd_pixel_store (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  rlsd_pkg::store_wr_t                     wr,
  input  logic [rlsd_pkg::PIX_W-1:0]              rd_idx,
  output logic [rlsd_pkg::BITS_PER_PIXEL-1:0]     rd_data
);
  import rlsd_pkg::*;

  logic [BITS_PER_PIXEL-1:0] pix_r [NUM_PIXELS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_PIXELS; i++) pix_r[i] <= '0;
    end else if (wr.en) begin
      pix_r[wr.idx] <= wr.data;
    end
  end

  assign rd_data = pix_r[rd_idx];

endmodule

// ===== design/rlsd_engine.sv =====
// rlsd_engine: line timing state (phase, pointers, counters) and per-word result.
// Depends on rlsd_pkg; reads pixels from rlsd_pixel_store.
module rlsd_engine (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                fire,
  input  rlsd_pkg::item_t                     item,
  input  rlsd_pkg::cfg_t                      cfg,
  input  logic [rlsd_pkg::BITS_PER_PIXEL-1:0] rd_data,
  output logic [rlsd_pkg::PIX_W-1:0]          rd_idx,
  output rlsd_pkg::store_wr_t                 wr,
  output rlsd_pkg::res_t                      res
);
  import rlsd_pkg::*;

  phase_t           phase_r, phase_nxt;
  logic [PIX_W-1:0] pp_r, pp_nxt;
  logic [BIT_W-1:0] bp_r, bp_nxt;
  logic [9:0]       tick_r, tick_nxt;
  logic [15:0]      gap_r, gap_nxt;

  logic             is_write, is_start, is_tick, idle, start_ok;
  logic [CNT_W-1:0] ppf;
  logic             bit_end, pix_end, frame_end, gap_end;
  logic [15:0]      gap_inc;
  phase_t           ev_phase;
  logic [BIT_W-1:0] ev_bp;
  logic [9:0]       ev_tick;
  logic [BIT_W-1:0] bit_sel;
  logic [7:0]       high_ticks;

  assign idle     = (phase_r == PH_IDLE);
  assign is_write = (item.operation == OP_WRITE);
  assign is_start = (item.operation == OP_START);
  assign is_tick  = (item.operation == OP_TICK);
  assign start_ok = is_start && idle;

  always_comb begin
    if (cfg.leds == 3'd0) ppf = CNT_W'(1);
    else if (32'(cfg.leds) > NUM_PIXELS) ppf = CNT_W'(NUM_PIXELS);
    else ppf = CNT_W'(cfg.leds);
  end

  assign bit_end   = ({1'b0, tick_r} + 11'd1) >= {1'b0, cfg.period};
  assign pix_end   = bp_r >= BIT_W'(BITS_PER_PIXEL - 1);
  assign frame_end = (CNT_W'(pp_r) + CNT_W'(1)) >= ppf;
  assign gap_inc   = gap_r + 16'd1;
  assign gap_end   = gap_inc >= cfg.latch_gap;

  // store write port
  always_comb begin
    wr.en   = fire && is_write && idle && (32'(item.pixel_index) < NUM_PIXELS);
    wr.idx  = PIX_W'(item.pixel_index);
    wr.data = {item.green, item.red, item.blue};
  end

  // next state
  always_comb begin
    phase_nxt = phase_r;
    pp_nxt    = pp_r;
    bp_nxt    = bp_r;
    tick_nxt  = tick_r;
    gap_nxt   = gap_r;
    if (fire) begin
      if (start_ok) begin
        phase_nxt = PH_SEND;
        pp_nxt    = '0;
        bp_nxt    = '0;
        tick_nxt  = '0;
        gap_nxt   = '0;
      end else if (is_tick) begin
        unique case (phase_r)
          PH_SEND: begin
            if (bit_end) begin
              tick_nxt = '0;
              if (pix_end) begin
                bp_nxt = '0;
                if (frame_end) begin
                  pp_nxt    = '0;
                  gap_nxt   = '0;
                  phase_nxt = (cfg.latch_gap == 16'd0) ? PH_IDLE : PH_LATCH;
                end else begin
                  pp_nxt = pp_r + PIX_W'(1);
                end
              end else begin
                bp_nxt = bp_r + BIT_W'(1);
              end
            end else begin
              tick_nxt = tick_r + 10'd1;
            end
          end
          PH_LATCH: begin
            if (gap_end) begin
              gap_nxt   = '0;
              phase_nxt = PH_IDLE;
            end else begin
              gap_nxt = gap_inc;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      pp_r    <= '0;
      bp_r    <= '0;
      tick_r  <= '0;
      gap_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      pp_r    <= pp_nxt;
      bp_r    <= bp_nxt;
      tick_r  <= tick_nxt;
      gap_r   <= gap_nxt;
    end
  end

  // outputs: a tick shows the level before it, any other word the level after
  always_comb begin
    if (start_ok) begin
      ev_phase = PH_SEND;
      ev_bp    = '0;
      ev_tick  = '0;
      rd_idx   = '0;
    end else begin
      ev_phase = phase_r;
      ev_bp    = bp_r;
      ev_tick  = tick_r;
      rd_idx   = pp_r;
    end
    bit_sel    = BIT_W'(BITS_PER_PIXEL - 1) - ev_bp;
    high_ticks = rd_data[bit_sel] ? cfg.one_high : cfg.zero_high;

    res.line_level = (ev_phase == PH_SEND) && (32'(ev_bp) < BITS_PER_PIXEL) &&
                     (ev_tick < {2'b00, high_ticks});
    res.busy_res   = (phase_nxt != PH_IDLE);
    res.frame_done = is_tick &&
                     (((phase_r == PH_SEND) && bit_end && pix_end && frame_end &&
                       (cfg.latch_gap == 16'd0)) ||
                      ((phase_r == PH_LATCH) && gap_end));
  end

endmodule

// ===== design/rgb_led_serial_driver.sv =====
// Top level of the RGB LED serial driver: word register, config, engine, result register.
// Depends on rlsd_pkg, rlsd_if, rlsd_pixel_store, rlsd_engine.
//
//  channel  | dir | handshake         | payload
//  ---------+-----+-------------------+-----------------------------------------
//  in_ch    | in  | valid / ready     | operation, pixel_index, red, green, blue
//  out_ch   | out | valid / ready     | line_level, busy_res, frame_done
//  cfg_*    | in  | cfg_we, no wait   | cfg_index, cfg_wdata
//
// One word per cycle sustained while out_ch.ready stays high; the result passes through
// the word register, engine logic, then the result register.
// Each word gives exactly one result word.
// rst_n (synchronous) clears the pixel store, timing state, valid flags and config to defaults.
// A stalled result holds; in_ch.ready drops only while both registers are full.
module rgb_led_serial_driver (
  input  logic                                 clk,
  input  logic                                 rst_n,
  rlsd_in_if.sink                              in_ch,
  rlsd_out_if.source                           out_ch,
  input  logic                                 cfg_we,
  input  logic [rlsd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rlsd_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import rlsd_pkg::*;

  cfg_t      cfg_r;
  item_t     item_r;
  logic      in_valid_r;
  res_t      res_r, res_c;
  logic      out_valid_r;
  logic      fire;
  store_wr_t wr;
  logic [PIX_W-1:0]          rd_idx;
  logic [BITS_PER_PIXEL-1:0] rd_data;

  assign fire        = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.one_high  <= RST_ONE_HIGH;
      cfg_r.zero_high <= RST_ZERO_HIGH;
      cfg_r.period    <= RST_PERIOD;
      cfg_r.latch_gap <= RST_LATCH_GAP;
      cfg_r.leds      <= RST_LEDS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ONE_HIGH:  cfg_r.one_high  <= cfg_wdata[7:0];
        CFG_ZERO_HIGH: cfg_r.zero_high <= cfg_wdata[7:0];
        CFG_PERIOD:    cfg_r.period    <= cfg_wdata[9:0];
        CFG_LATCH_GAP: cfg_r.latch_gap <= cfg_wdata[15:0];
        CFG_LEDS:      cfg_r.leds      <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item_r.operation   <= in_ch.operation;
      item_r.pixel_index <= in_ch.pixel_index;
      item_r.red         <= in_ch.red;
      item_r.green       <= in_ch.green;
      item_r.blue        <= in_ch.blue;
    end
  end

  rlsd_pixel_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (wr),
    .rd_idx  (rd_idx),
    .rd_data (rd_data)
  );

  rlsd_engine u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (fire),
    .item    (item_r),
    .cfg     (cfg_r),
    .rd_data (rd_data),
    .rd_idx  (rd_idx),
    .wr      (wr),
    .res     (res_c)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) res_r <= res_c;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.line_level = res_r.line_level;
  assign out_ch.busy_res   = res_r.busy_res;
  assign out_ch.frame_done = res_r.frame_done;

endmodule

// ===== design/rlsd_checker.sv =====
// rlsd_checker: port-level checks on the RGB LED serial driver, bound to the top level.
// Depends on rgb_led_serial_driver (bound to its channel ports).
module rlsd_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_line_level,
  input logic out_busy_res,
  input logic out_frame_done
);

  // result word held until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  // frame end leaves the driver idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_done |-> !out_busy_res)
    else $error("frame_done with busy_res set");

  // line only driven high during a frame, or on the tick that ends it
  a_level_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_line_level |-> (out_busy_res || out_frame_done))
    else $error("line high while idle");

  // reset empties the result register
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // with the result side free, input is never refused
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

endmodule

bind rgb_led_serial_driver rlsd_checker u_rlsd_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_line_level (out_ch.line_level),
  .out_busy_res   (out_ch.busy_res),
  .out_frame_done (out_ch.frame_done)
);
